/* rtl/fdiv_pkg.sv */
// Package for the single-precision divider: widths, constants and cell payload type.
`default_nettype none
package fdiv_pkg;
  localparam int QW = 25;
  localparam int NCELL = 25;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [9:0] BIAS = 10'd127;
  localparam logic [9:0] EXP_MAX = 10'd255;

  typedef struct packed {
    logic        vld;
    logic        zero_a;
    logic        zero_b;
    logic        sign;
    logic [9:0]  exp;
    logic [24:0] rem;
    logic [23:0] dvs;
    logic [QW-1:0] quo;
  } cell_t;
endpackage
`default_nettype wire

/* rtl/fdiv_cell.sv */
// One restoring-division cell: one quotient bit per cycle, handed to the next cell.
`default_nettype none
module fdiv_cell
  import fdiv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cell_t      d_in,
  output cell_t      d_out
);
  cell_t       d_r;
  cell_t       d_nxt;
  logic [25:0] diff;

  always_comb begin
    d_nxt = d_in;
    diff  = {1'b0, d_in.rem} - {2'b00, d_in.dvs};
    if (!diff[25]) begin
      d_nxt.rem = {diff[23:0], 1'b0};
      d_nxt.quo = {d_in.quo[QW-2:0], 1'b1};
    end else begin
      d_nxt.rem = {d_in.rem[23:0], 1'b0};
      d_nxt.quo = {d_in.quo[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_nxt.vld;
    end
    d_r.zero_a <= d_nxt.zero_a;
    d_r.zero_b <= d_nxt.zero_b;
    d_r.sign   <= d_nxt.sign;
    d_r.exp    <= d_nxt.exp;
    d_r.rem    <= d_nxt.rem;
    d_r.dvs    <= d_nxt.dvs;
    d_r.quo    <= d_nxt.quo;
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

/* rtl/float32_divider.sv */
// Top level of the single-precision divider: a row of division cells and result packing.
//
//  channel | ports                                   | handshake
//  in      | in_dividend_bits, in_divisor_bits       | start high, busy low
//  out     | out_quotient_bits, out_overflow, ...    | out_valid, one cycle
//
// out_valid rises once the transfer has passed through the 25 quotient-bit
// cells (the first captures at the transfer edge) and then the output register.
// One item per cycle; busy is always low.
// Reset clears the valid bits of every cell and of the output.
// The receiver cannot stall; results leave on the strobe.
`default_nettype none
module float32_divider
  import fdiv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_dividend_bits,
  input  wire logic [31:0] in_divisor_bits,
  output logic             out_valid,
  output logic [31:0]      out_quotient_bits,
  output logic             out_overflow,
  output logic             out_underflow
);
  cell_t       chain [NCELL+1];
  cell_t       last;
  logic [9:0]  e;
  logic [23:0] q;
  logic [31:0] res_nxt;
  logic        ovf_nxt;
  logic        unf_nxt;
  logic        out_valid_r;
  logic [31:0] res_r;
  logic        ovf_r;
  logic        unf_r;

  assign busy = 1'b0;

  always_comb begin
    chain[0].vld    = start;
    chain[0].zero_a = (in_dividend_bits[30:0] == 31'd0);
    chain[0].zero_b = (in_divisor_bits[30:0] == 31'd0);
    chain[0].sign   = in_dividend_bits[31] ^ in_divisor_bits[31];
    chain[0].exp    = {2'b00, in_dividend_bits[30:23]} - {2'b00, in_divisor_bits[30:23]}
                      + BIAS;
    chain[0].rem    = {2'b01, in_dividend_bits[22:0]};
    chain[0].dvs    = {1'b1, in_divisor_bits[22:0]};
    chain[0].quo    = '0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fdiv_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  assign last = chain[NCELL];

  always_comb begin
    e = last.exp;
    q = last.quo[24:1];
    if (!q[23] && !e[9] && (e != 10'd0)) begin
      q = {last.quo[23:1], 1'b0};
      e = e - 10'd1;
    end
    res_nxt = '0;
    ovf_nxt = 1'b0;
    unf_nxt = 1'b0;
    if (last.zero_a) begin
      res_nxt = '0;
    end else if (last.zero_b) begin
      res_nxt = POS_INF;
    end else if (!e[9] && (e >= EXP_MAX)) begin
      res_nxt = POS_INF;
      ovf_nxt = 1'b1;
    end else if (e[9] || (e == 10'd0)) begin
      unf_nxt = 1'b1;
    end else begin
      res_nxt = {last.sign, e[7:0], q[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
    res_r <= res_nxt;
    ovf_r <= ovf_nxt;
    unf_r <= unf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_quotient_bits = res_r;
  assign out_overflow      = ovf_r;
  assign out_underflow     = unf_r;
endmodule
`default_nettype wire

/* rtl/fdiv_checker.sv */
// Port checker for the single-precision divider, bound to the top level.
`default_nettype none
module fdiv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_quotient_bits,
  input wire logic        out_overflow,
  input wire logic        out_underflow
);
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow && out_underflow)) else $error("both flags set");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_quotient_bits == 32'h7F80_0000))
    else $error("overflow result not +inf");
  a_unf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_underflow) |-> (out_quotient_bits == 32'd0))
    else $error("underflow result not +0");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##26 out_valid) else $error("result missing");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind float32_divider fdiv_checker u_fdiv_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_quotient_bits(out_quotient_bits), .out_overflow(out_overflow),
  .out_underflow(out_underflow)
);
`default_nettype wire

/* test/tb_top.sv */
// Testbench for float32_divider: directed table and random operand pairs checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import fdiv_pkg::*;

  typedef struct {
    logic [31:0] quo;
    logic        ovf;
    logic        unf;
  } quot_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    quot_t       res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_dividend_bits;
  logic [31:0] in_divisor_bits;
  logic        out_valid;
  logic [31:0] out_quotient_bits;
  logic        out_overflow;
  logic        out_underflow;

  quot_t pending_quots[$];
  int    errors;
  int    cycles;
  int    gap_pct;
  row_t  dir_rows[$];

  float32_divider uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_dividend_bits(in_dividend_bits), .in_divisor_bits(in_divisor_bits),
    .out_valid(out_valid), .out_quotient_bits(out_quotient_bits),
    .out_overflow(out_overflow), .out_underflow(out_underflow)
  );

  function automatic quot_t divide_bits(logic [31:0] a, logic [31:0] b);
    quot_t r;
    logic [47:0] num;
    logic [23:0] den;
    logic [47:0] q;
    int e;
    r.quo = '0;
    r.ovf = 1'b0;
    r.unf = 1'b0;
    if (a[30:0] == 0) return r;
    if (b[30:0] == 0) begin
      r.quo = POS_INF;
      return r;
    end
    num = {1'b1, a[22:0]} << 23;
    den = {1'b1, b[22:0]};
    q = num / den;
    e = int'(a[30:23]) - int'(b[30:23]) + 127;
    if (!q[23] && e > 0) begin
      q = q << 1;
      e--;
    end
    if (e >= 255) begin
      r.quo = POS_INF;
      r.ovf = 1'b1;
    end else if (e <= 0) begin
      r.unf = 1'b1;
    end else begin
      r.quo = {a[31] ^ b[31], e[7:0], q[22:0]};
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:0] = '0;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'h00;
      3: v[30:23] = $urandom_range(0, 20);
      4: v[30:23] = $urandom_range(235, 255);
      default: v[30:23] = $urandom_range(100, 154);
    endcase
    return v;
  endfunction

  function automatic row_t mk(logic [31:0] a, logic [31:0] b, logic known,
                              logic [31:0] q, logic o, logic u);
    row_t r;
    r.a = a;
    r.b = b;
    r.known = known;
    r.res.quo = q;
    r.res.ovf = o;
    r.res.unf = u;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_pair(logic [31:0] a, logic [31:0] b, logic known, quot_t res);
    quot_t p;
    p = known ? res : divide_bits(a, b);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_dividend_bits <= a;
    in_divisor_bits <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_quots.push_back(p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_quots.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    quot_t x;
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb_top: done, errors");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_quots.size() == 0) begin
        $error("result with no transfer pending: %h", out_quotient_bits);
        errors = errors + 1;
      end else begin
        x = pending_quots.pop_front();
        if (out_quotient_bits !== x.quo) begin
          $error("quotient_bits expected %h actual %h", x.quo, out_quotient_bits);
          errors = errors + 1;
        end
        if (out_overflow !== x.ovf) begin
          $error("overflow expected %b actual %b", x.ovf, out_overflow);
          errors = errors + 1;
        end
        if (out_underflow !== x.unf) begin
          $error("underflow expected %b actual %b", x.unf, out_underflow);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    quot_t none;
    errors = 0;
    cycles = 0;
    gap_pct = 0;
    none = '{default: 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_dividend_bits = '0;
    in_divisor_bits = '0;
    dir_rows.push_back(mk(32'h0000_0000, 32'h3F80_0000, 1, 32'h0000_0000, 0, 0));
    dir_rows.push_back(mk(32'h8000_0000, 32'h0000_0000, 1, 32'h0000_0000, 0, 0));
    dir_rows.push_back(mk(32'h3F80_0000, 32'h0000_0000, 1, POS_INF, 0, 0));
    dir_rows.push_back(mk(32'hBF80_0000, 32'h8000_0000, 1, POS_INF, 0, 0));
    dir_rows.push_back(mk(32'h3F80_0000, 32'h3F80_0000, 1, 32'h3F80_0000, 0, 0));
    dir_rows.push_back(mk(32'hBF80_0000, 32'h3F80_0000, 1, 32'hBF80_0000, 0, 0));
    dir_rows.push_back(mk(32'h7F7F_FFFF, 32'h0080_0000, 1, POS_INF, 1, 0));
    dir_rows.push_back(mk(32'hFF7F_FFFF, 32'h0080_0000, 1, POS_INF, 1, 0));
    dir_rows.push_back(mk(32'h0080_0000, 32'h7F7F_FFFF, 1, 32'h0000_0000, 0, 1));
    dir_rows.push_back(mk(32'h4000_0000, 32'h3FC0_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h3F80_0000, 32'h3FFF_FFFF, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h3F80_0000, 32'h7F00_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h7FC0_0000, 32'h3F80_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h7F80_0000, 32'h7F80_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h0000_0001, 32'h007F_FFFF, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h0080_0000, 32'h3F80_0001, 0, 0, 0, 0));
    dir_rows.push_back(mk(32'h7FFF_FFFF, 32'h0000_0001, 0, 0, 0, 0));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].known,
                                    dir_rows[i].res);
    drain();
    for (int n = 0; n < 1350; n++) begin
      gap_pct = (n >= 400 && n < 700) ? 0 : 30;
      if (n == 900) drain();
      send_pair(pick_operand(), pick_operand(), 0, none);
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_quots.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

/* float32_divider.f */
rtl/fdiv_pkg.sv
rtl/fdiv_cell.sv
rtl/float32_divider.sv
rtl/fdiv_checker.sv
test/tb_top.sv
